// ===== src/imusbo_pkg.sv =====
// Shared constants, types and remap tables for the IMU scale, bias and orientation block.
`default_nettype none

package imusbo_pkg;

    localparam int SAMPLE_COUNT = 100;

    localparam int RAW_W      = 16;
    localparam int ACC_W      = 21;
    localparam int GYR_W      = 28;
    localparam int ACC_BIAS_W = 21;
    localparam int GYR_BIAS_W = 27;
    localparam int ACC_CALC_W = 22;
    localparam int GYR_CALC_W = 29;
    localparam int NUM_AXES   = 6;
    localparam int AXIS_W     = 3;
    localparam int NUM_ACCEL  = 3;

    // x2 and x128 scale used for the bias, and as base of the range shifts
    localparam int ACCEL_SHIFT = 1;
    localparam int GYRO_SHIFT  = 7;

    localparam int SUM_W     = $clog2(32768 * SAMPLE_COUNT) + 1;
    localparam int CNT_W     = $clog2(SAMPLE_COUNT + 1);
    localparam int DIV_IN_W  = SUM_W + GYRO_SHIFT;
    localparam int DIV_SHIFT = DIV_IN_W + $clog2(SAMPLE_COUNT);
    localparam int RECIP_W   = DIV_IN_W + 1;
    localparam int PROD_W    = DIV_IN_W + RECIP_W;
    localparam int Q_W       = 23;

    // ceil(2^DIV_SHIFT / SAMPLE_COUNT): exact floor division for all divider inputs
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << DIV_SHIFT)
        + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT));

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLE_COUNT - 1);

    localparam logic signed [ACC_BIAS_W-1:0] ONE_G = ACC_BIAS_W'(32768);

    localparam logic [2:0] GYRO_SEL_MAX = 3'd4;

    localparam logic OP_MEASURE   = 1'b0;
    localparam logic OP_CALIBRATE = 1'b1;
    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_BIAS    = 1'b1;

    localparam logic [1:0] CFG_ACCEL_RANGE = 2'd0;
    localparam logic [1:0] CFG_GYRO_RANGE  = 2'd1;
    localparam logic [1:0] CFG_ORIENT      = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [AXIS_W-1:0] axis;
    } div_tag_t;

    // source raw axis for output axis i
    function automatic logic [1:0] remap_src(input logic [2:0] o, input logic [1:0] i);
        logic [1:0] s;
        case (o)
            3'd0, 3'd2: s = i;
            3'd1, 3'd3: s = (i == 2'd0) ? 2'd1 : (i == 2'd1) ? 2'd0 : 2'd2;
            3'd4, 3'd6: s = (i == 2'd0) ? 2'd2 : (i == 2'd1) ? 2'd1 : 2'd0;
            default:    s = (i == 2'd0) ? 2'd2 : (i == 2'd1) ? 2'd0 : 2'd1;
        endcase
        return s;
    endfunction

    // negate flags for output X, Y, Z packed as {Z, Y, X}
    function automatic logic remap_neg(input logic [2:0] o, input logic [1:0] i);
        logic [2:0] n;
        case (o)
            3'd0:    n = 3'b000;
            3'd1:    n = 3'b001;
            3'd2:    n = 3'b011;
            3'd3:    n = 3'b010;
            3'd4:    n = 3'b111;
            3'd5:    n = 3'b101;
            3'd6:    n = 3'b001;
            default: n = 3'b011;
        endcase
        return n[i];
    endfunction

    function automatic logic [1:0] gravity_axis(input logic [2:0] o);
        logic [1:0] g;
        case (o)
            3'd4, 3'd6: g = 2'd0;
            3'd5, 3'd7: g = 2'd1;
            default:    g = 2'd2;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

// ===== src/imusbo_bias_div.sv =====
// Two-stage signed divide of a calibration sum by the sample count, via reciprocal multiply.
`default_nettype none

module imusbo_bias_div (
    input  wire                                     aclk,
    input  wire                                     aresetn,
    input  wire imusbo_pkg::div_tag_t               in_tag,
    input  wire logic signed [imusbo_pkg::SUM_W-1:0] in_sum,
    output imusbo_pkg::div_tag_t                    out_tag,
    output logic signed [imusbo_pkg::Q_W:0]         out_quot
);

    logic [imusbo_pkg::SUM_W-1:0]    mag;
    logic [imusbo_pkg::DIV_IN_W-1:0] v_next;
    logic [imusbo_pkg::PROD_W-1:0]   prod_next;
    logic [imusbo_pkg::Q_W-1:0]      quot;
    logic signed [imusbo_pkg::Q_W:0] quot_s;

    imusbo_pkg::div_tag_t            tag1_reg;
    imusbo_pkg::div_tag_t            tag2_reg;
    logic [imusbo_pkg::DIV_IN_W-1:0] v_reg;
    logic                            neg1_reg;
    logic [imusbo_pkg::PROD_W-1:0]   prod_reg;
    logic                            neg2_reg;

    always_comb begin
        mag = in_sum[imusbo_pkg::SUM_W-1] ? imusbo_pkg::SUM_W'(-in_sum)
                                          : imusbo_pkg::SUM_W'(in_sum);
        if (in_tag.axis >= imusbo_pkg::AXIS_W'(imusbo_pkg::NUM_ACCEL)) begin
            v_next = imusbo_pkg::DIV_IN_W'(mag) << imusbo_pkg::GYRO_SHIFT;
        end else begin
            v_next = imusbo_pkg::DIV_IN_W'(mag) << imusbo_pkg::ACCEL_SHIFT;
        end
    end

    assign prod_next = imusbo_pkg::PROD_W'(v_reg) * imusbo_pkg::PROD_W'(imusbo_pkg::RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end else begin
            tag1_reg <= in_tag;
            tag2_reg <= tag1_reg;
        end
        v_reg    <= v_next;
        neg1_reg <= in_sum[imusbo_pkg::SUM_W-1];
        prod_reg <= prod_next;
        neg2_reg <= neg1_reg;
    end

    // truncation toward zero: divide the magnitude, then restore the sign
    assign quot     = prod_reg[imusbo_pkg::DIV_SHIFT +: imusbo_pkg::Q_W];
    assign quot_s   = signed'({1'b0, quot});
    assign out_quot = neg2_reg ? -quot_s : quot_s;
    assign out_tag  = tag2_reg;

endmodule

`default_nettype wire

// ===== src/imu_sample_scale_bias_orient.sv =====
// IMU sample conditioning top level: range scaling, bias removal, axis remap and bias calibration.
// A measure request is taken every clock outside calibration and its conditioned sample is valid
// in the output register from the next cycle; a new request is taken in the same cycle a waiting
// result leaves, so s_ready follows m_ready while a result is held.
// Calibration requests are also taken one per clock, under the same conditions. The request that completes the sample
// set holds s_ready low while the biases are worked out and until they can be loaded into the output register: the six
// biases are worked out one axis a cycle through a shared two-stage reciprocal multiplier
// (issued in state ST_DIV, drained in ST_DRAIN), then the biases are emitted.
`default_nettype none

module imu_sample_scale_bias_orient (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [1:0]                       cfg_index,
    input  wire logic [2:0]                       cfg_data,
    input  wire                                   s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_op,
    input  wire logic signed [imusbo_pkg::RAW_W-1:0] s_accel_raw_x,
    input  wire logic signed [imusbo_pkg::RAW_W-1:0] s_accel_raw_y,
    input  wire logic signed [imusbo_pkg::RAW_W-1:0] s_accel_raw_z,
    input  wire logic signed [imusbo_pkg::RAW_W-1:0] s_gyro_raw_x,
    input  wire logic signed [imusbo_pkg::RAW_W-1:0] s_gyro_raw_y,
    input  wire logic signed [imusbo_pkg::RAW_W-1:0] s_gyro_raw_z,
    output logic                                  m_valid,
    input  wire                                   m_ready,
    output logic                                  m_kind,
    output logic signed [imusbo_pkg::ACC_W-1:0]   m_accel_x,
    output logic signed [imusbo_pkg::ACC_W-1:0]   m_accel_y,
    output logic signed [imusbo_pkg::ACC_W-1:0]   m_accel_z,
    output logic signed [imusbo_pkg::GYR_W-1:0]   m_gyro_x,
    output logic signed [imusbo_pkg::GYR_W-1:0]   m_gyro_y,
    output logic signed [imusbo_pkg::GYR_W-1:0]   m_gyro_z
);

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DIV,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t state_reg;

    logic [1:0] accel_range_reg;
    logic [2:0] gyro_range_reg;
    logic [2:0] orient_reg;

    logic signed [imusbo_pkg::ACC_BIAS_W-1:0] acc_bias_reg [3];
    logic signed [imusbo_pkg::GYR_BIAS_W-1:0] gyr_bias_reg [3];
    logic signed [imusbo_pkg::SUM_W-1:0]      sums_reg [imusbo_pkg::NUM_AXES];
    logic [imusbo_pkg::CNT_W-1:0]             cnt_reg;
    logic [imusbo_pkg::AXIS_W-1:0]            iss_reg;

    logic                                     m_valid_reg;
    logic                                     m_kind_reg;
    logic signed [imusbo_pkg::ACC_W-1:0]      m_acc_reg [3];
    logic signed [imusbo_pkg::GYR_W-1:0]      m_gyr_reg [3];

    logic signed [imusbo_pkg::RAW_W-1:0]      raw [imusbo_pkg::NUM_AXES];
    logic [2:0]                               acc_shift;
    logic [2:0]                               gyr_sel;
    logic [3:0]                               gyr_shift;
    logic signed [imusbo_pkg::ACC_CALC_W-1:0] acc_cal [3];
    logic signed [imusbo_pkg::GYR_CALC_W-1:0] gyr_cal [3];
    logic signed [imusbo_pkg::ACC_CALC_W-1:0] acc_pick;
    logic signed [imusbo_pkg::GYR_CALC_W-1:0] gyr_pick;
    logic signed [imusbo_pkg::ACC_W-1:0]      acc_out [3];
    logic signed [imusbo_pkg::GYR_W-1:0]      gyr_out [3];
    logic [1:0]                               src;
    logic                                     out_free;
    logic                                     out_load;

    imusbo_pkg::div_tag_t                     div_in_tag;
    imusbo_pkg::div_tag_t                     div_out_tag;
    logic signed [imusbo_pkg::Q_W:0]          div_quot;
    logic signed [imusbo_pkg::ACC_BIAS_W-1:0] acc_wb;
    logic signed [imusbo_pkg::ACC_BIAS_W-1:0] acc_wb_adj;

    assign raw[0] = s_accel_raw_x;
    assign raw[1] = s_accel_raw_y;
    assign raw[2] = s_accel_raw_z;
    assign raw[3] = s_gyro_raw_x;
    assign raw[4] = s_gyro_raw_y;
    assign raw[5] = s_gyro_raw_z;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_RUN) && out_free;
    assign out_load  = ((state_reg == ST_RUN) && s_valid && s_ready
                        && (s_op == imusbo_pkg::OP_MEASURE))
                       || ((state_reg == ST_EMIT) && out_free);

    // measure path: scale, remove bias, remap
    always_comb begin
        acc_shift = 3'(imusbo_pkg::ACCEL_SHIFT) + {1'b0, accel_range_reg};
        gyr_sel   = (gyro_range_reg > imusbo_pkg::GYRO_SEL_MAX) ? imusbo_pkg::GYRO_SEL_MAX
                                                                : gyro_range_reg;
        gyr_shift = 4'(imusbo_pkg::GYRO_SHIFT) + {1'b0, gyr_sel};
        for (int i = 0; i < 3; i++) begin
            acc_cal[i] = (imusbo_pkg::ACC_CALC_W'(raw[i]) <<< acc_shift)
                         - imusbo_pkg::ACC_CALC_W'(acc_bias_reg[i]);
            gyr_cal[i] = (imusbo_pkg::GYR_CALC_W'(raw[i + 3]) <<< gyr_shift)
                         - imusbo_pkg::GYR_CALC_W'(gyr_bias_reg[i]);
        end
        acc_pick = '0;
        gyr_pick = '0;
        src      = '0;
        for (int i = 0; i < 3; i++) begin
            src      = imusbo_pkg::remap_src(orient_reg, 2'(i));
            acc_pick = acc_cal[src];
            gyr_pick = gyr_cal[src];
            if (imusbo_pkg::remap_neg(orient_reg, 2'(i))) begin
                acc_pick = -acc_pick;
                gyr_pick = -gyr_pick;
            end
            acc_out[i] = acc_pick[imusbo_pkg::ACC_W-1:0];
            gyr_out[i] = gyr_pick[imusbo_pkg::GYR_W-1:0];
        end
    end

    assign div_in_tag = '{valid: (state_reg == ST_DIV), axis: iss_reg};

    imusbo_bias_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_tag   (div_in_tag),
        .in_sum   (sums_reg[iss_reg]),
        .out_tag  (div_out_tag),
        .out_quot (div_quot)
    );

    // one g comes off the gravity axis
    always_comb begin
        acc_wb = imusbo_pkg::ACC_BIAS_W'(div_quot);
        if (div_out_tag.axis[1:0] == imusbo_pkg::gravity_axis(orient_reg)) begin
            acc_wb_adj = (acc_wb > 0) ? acc_wb - imusbo_pkg::ONE_G
                                      : acc_wb + imusbo_pkg::ONE_G;
        end else begin
            acc_wb_adj = acc_wb;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_RUN;
            accel_range_reg <= 2'd3;
            gyro_range_reg  <= 3'd4;
            orient_reg      <= 3'd0;
            cnt_reg         <= '0;
            iss_reg         <= '0;
            m_valid_reg     <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                acc_bias_reg[i] <= '0;
                gyr_bias_reg[i] <= '0;
            end
            for (int i = 0; i < imusbo_pkg::NUM_AXES; i++) begin
                sums_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    imusbo_pkg::CFG_ACCEL_RANGE: accel_range_reg <= cfg_data[1:0];
                    imusbo_pkg::CFG_GYRO_RANGE:  gyro_range_reg  <= cfg_data;
                    imusbo_pkg::CFG_ORIENT:      orient_reg      <= cfg_data;
                    default: ;
                endcase
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (div_out_tag.valid) begin
                if (div_out_tag.axis < imusbo_pkg::AXIS_W'(imusbo_pkg::NUM_ACCEL)) begin
                    acc_bias_reg[div_out_tag.axis[1:0]] <= acc_wb_adj;
                end else begin
                    gyr_bias_reg[2'(div_out_tag.axis - imusbo_pkg::AXIS_W'(imusbo_pkg::NUM_ACCEL))]
                        <= imusbo_pkg::GYR_BIAS_W'(div_quot);
                end
            end

            case (state_reg)
                ST_RUN: begin
                    if (s_valid && s_ready) begin
                        if (s_op == imusbo_pkg::OP_MEASURE) begin
                            m_kind_reg  <= imusbo_pkg::KIND_SAMPLE;
                            for (int i = 0; i < 3; i++) begin
                                m_acc_reg[i] <= acc_out[i];
                                m_gyr_reg[i] <= gyr_out[i];
                            end
                        end else begin
                            for (int i = 0; i < imusbo_pkg::NUM_AXES; i++) begin
                                sums_reg[i] <= sums_reg[i] + imusbo_pkg::SUM_W'(raw[i]);
                            end
                            if (cnt_reg == imusbo_pkg::CNT_LAST) begin
                                state_reg <= ST_DIV;
                                iss_reg   <= '0;
                            end else begin
                                cnt_reg <= cnt_reg + 1'b1;
                            end
                        end
                    end
                end
                ST_DIV: begin
                    iss_reg <= iss_reg + 1'b1;
                    if (iss_reg == imusbo_pkg::AXIS_W'(imusbo_pkg::NUM_AXES - 1)) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (div_out_tag.valid &&
                        div_out_tag.axis == imusbo_pkg::AXIS_W'(imusbo_pkg::NUM_AXES - 1)) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_kind_reg  <= imusbo_pkg::KIND_BIAS;
                        for (int i = 0; i < 3; i++) begin
                            m_acc_reg[i] <= imusbo_pkg::ACC_W'(acc_bias_reg[i]);
                            m_gyr_reg[i] <= imusbo_pkg::GYR_W'(gyr_bias_reg[i]);
                        end
                        for (int i = 0; i < imusbo_pkg::NUM_AXES; i++) begin
                            sums_reg[i] <= '0;
                        end
                        cnt_reg   <= '0;
                        state_reg <= ST_RUN;
                    end
                end
                default: begin
                    state_reg <= ST_RUN;
                end
            endcase
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_kind    = m_kind_reg;
    assign m_accel_x = m_acc_reg[0];
    assign m_accel_y = m_acc_reg[1];
    assign m_accel_z = m_acc_reg[2];
    assign m_gyro_x  = m_gyr_reg[0];
    assign m_gyro_y  = m_gyr_reg[1];
    assign m_gyro_z  = m_gyr_reg[2];

endmodule

`default_nettype wire
